[sv/pdev_pkg.sv]
// ----------------------------------------------------------------------------
// pdev_pkg - shared types and constants for the Poisson deviance accumulator
// Field widths, fixed-point constants and the core request/result bundles.
// ----------------------------------------------------------------------------
package pdev_pkg;

  localparam int VAL_W   = 32;            // Q16.16 count
  localparam int LOG_W   = 29;            // 5 integer + 24 fraction bits
  localparam int FRAC_W  = 24;
  localparam int TERM_W  = 38;            // largest per-bin term, Q22.16
  localparam int SUM_W   = 48;            // Q32.16
  localparam int BIN_W   = 8;
  localparam int MAX_BINS = 128;          // bins past this are not summed

  localparam logic [VAL_W-1:0] LN2_Q20 = 32'd726817;  // ln(2) * 2^20
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // request from the bin sequencer into the term core
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] pred;
    logic [VAL_W-1:0] obs;
  } pdev_req_t;

  // result from the term core
  typedef struct packed {
    logic              done;
    logic [TERM_W-1:0] term;
  } pdev_res_t;

endpackage

[sv/pdev_mul.sv]
// ----------------------------------------------------------------------------
// pdev_mul - shared 32x32 multiplier
// Unsigned multiply with the full product registered.
// ----------------------------------------------------------------------------
module pdev_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

[sv/pdev_core.sv]
// ----------------------------------------------------------------------------
// pdev_core - per-bin likelihood term
// Sequences two fixed-point log2 evaluations and the ln scaling through the
// shared multiplier; returns max(0, (pred-obs) + obs*ln(obs/pred)).
// ----------------------------------------------------------------------------
module pdev_core (
  input  logic                clk,
  input  logic                rst,
  input  pdev_pkg::pdev_req_t req,
  output pdev_pkg::pdev_res_t res
);
  import pdev_pkg::*;

  localparam logic [3:0] C_IDLE = 4'd0;
  localparam logic [3:0] C_NORM = 4'd1;   // binary normalize, 5 steps
  localparam logic [3:0] C_SQ   = 4'd2;   // 24 squarings, one per cycle
  localparam logic [3:0] C_DIFF = 4'd3;
  localparam logic [3:0] C_MA   = 4'd4;   // obs * |D|
  localparam logic [3:0] C_MB   = 4'd5;   // low part * ln2
  localparam logic [3:0] C_MC   = 4'd6;   // high part * ln2
  localparam logic [3:0] C_MD   = 4'd7;   // combine and round
  localparam logic [3:0] C_FIN  = 4'd8;

  localparam logic [4:0] SQ_LAST = 5'(FRAC_W);

  logic [3:0]        state;
  logic [4:0]        cnt;
  logic              which;        // 0: log of obs, 1: log of pred
  logic [VAL_W-1:0]  x;
  logic [4:0]        p;
  logic [FRAC_W-1:0] frac;
  logic [LOG_W-1:0]  lg_obs;
  logic [LOG_W-1:0]  lg_pred;
  logic [VAL_W-1:0]  pred_r;
  logic [VAL_W-1:0]  obs_r;
  logic              neg;
  logic [LOG_W-1:0]  mag;
  logic [8:0]        thi;
  logic [51:0]       acc;
  logic [36:0]       lp;
  logic [TERM_W-1:0] term;
  logic              done;

  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       prod;
  logic [31:0]       m_sq;
  logic [LOG_W:0]    d;
  logic [60:0]       lp_sum;
  logic [38:0]       diff;
  logic [38:0]       tsum;

  pdev_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // squared mantissa back to Q1.31; top bit set means it reached 2.0
  assign m_sq   = prod[63] ? prod[63:32] : prod[62:31];
  assign d      = {1'b0, lg_obs} - {1'b0, lg_pred};
  assign lp_sum = {9'b0, acc} + {prod[28:0], 32'b0} + 61'(1 << 23);
  assign diff   = {7'b0, pred_r} - {7'b0, obs_r};
  assign tsum   = neg ? (diff - {2'b0, lp}) : (diff + {2'b0, lp});

  always_comb begin
    case (state)
      C_SQ: begin
        mul_a = (cnt == 5'd0) ? x : m_sq;
        mul_b = (cnt == 5'd0) ? x : m_sq;
      end
      C_MA: begin
        mul_a = obs_r;
        mul_b = {3'b0, mag};
      end
      C_MB: begin
        mul_a = prod[51:20];
        mul_b = LN2_Q20;
      end
      C_MC: begin
        mul_a = {23'b0, thi};
        mul_b = LN2_Q20;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (req.start) begin
            pred_r <= req.pred;
            obs_r  <= req.obs;
            if (req.obs == '0) begin
              term <= TERM_W'(req.pred);
              done <= 1'b1;
            end else begin
              x     <= req.obs;
              p     <= 5'd31;
              cnt   <= '0;
              which <= 1'b0;
              state <= C_NORM;
            end
          end
        end
        C_NORM: begin
          case (cnt)
            5'd0: if (x[31:16] == '0) begin x <= x << 16; p <= p - 5'd16; end
            5'd1: if (x[31:24] == '0) begin x <= x << 8;  p <= p - 5'd8;  end
            5'd2: if (x[31:28] == '0) begin x <= x << 4;  p <= p - 5'd4;  end
            5'd3: if (x[31:30] == '0) begin x <= x << 2;  p <= p - 5'd2;  end
            default: if (!x[31]) begin x <= x << 1; p <= p - 5'd1; end
          endcase
          if (cnt == 5'd4) begin
            cnt   <= '0;
            frac  <= '0;
            state <= C_SQ;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        C_SQ: begin
          if (cnt != 5'd0) begin
            frac <= {frac[FRAC_W-2:0], prod[63]};
          end
          if (cnt == SQ_LAST) begin
            if (!which) begin
              lg_obs <= {p, frac[FRAC_W-2:0], prod[63]};
              which  <= 1'b1;
              x      <= pred_r;
              p      <= 5'd31;
              cnt    <= '0;
              state  <= C_NORM;
            end else begin
              lg_pred <= {p, frac[FRAC_W-2:0], prod[63]};
              state   <= C_DIFF;
            end
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        C_DIFF: begin
          neg   <= d[LOG_W];
          mag   <= d[LOG_W] ? LOG_W'(-d) : d[LOG_W-1:0];
          state <= C_MA;
        end
        C_MA: state <= C_MB;
        C_MB: begin
          thi   <= prod[60:52];
          state <= C_MC;
        end
        C_MC: begin
          acc   <= prod[51:0];
          state <= C_MD;
        end
        C_MD: begin
          lp    <= lp_sum[60:24];
          state <= C_FIN;
        end
        C_FIN: begin
          term  <= tsum[38] ? '0 : tsum[TERM_W-1:0];  // rounding can dip below zero
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.term = term;

endmodule

[sv/poisson_deviance_accumulator.sv]
// ----------------------------------------------------------------------------
// poisson_deviance_accumulator - Poisson log-likelihood-ratio chi-square
//
// Takes one histogram bin per input beat (predicted and observed counts,
// Q16.16) and sums (pred-obs) + obs*ln(obs/pred) over bins numbered from
// first_bin up to 128 with a nonzero prediction; a zero observation adds pred.
// The beat flagged tlast emits 2*sum as Q32.16 on the output, clamped to all
// ones with tuser set on overflow, then clears the sum and restarts bin
// numbering at 1. One bin is handled at a time: a bin that gets a log term
// runs two log2 evaluations (5 normalize steps plus a run of squarings each)
// on the single shared 32x32 multiplier, then a difference step, the multiply
// and round steps, the term step, the handoff and the accumulate before the
// next beat is taken; a skipped bin goes straight to the accumulate, and one
// with a zero observation first gets pred back from the core. A last bin
// then passes a handoff to the output register. A result waiting on the
// output does not stop the next bins; only a second last bin waits for it.
// first_bin may be written whenever the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module poisson_deviance_accumulator (
  input  logic        clk,
  input  logic        rst,
  // configuration: first_bin
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // bin input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,    // [31:0] pred_value, [63:32] obs_value
  input  logic        s_tlast,    // last_bin
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,    // [47:0] deviance
  output logic [0:0]  m_tuser     // [0] saturated
);
  import pdev_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a bin
  localparam logic [1:0] S_RUN  = 2'd1;  // term core busy
  localparam logic [1:0] S_ADD  = 2'd2;  // accumulate term
  localparam logic [1:0] S_EMIT = 2'd3;  // hand result to output register

  logic [1:0]        state;
  logic [BIN_W-1:0]  first_bin;
  logic [BIN_W-1:0]  bin_number;
  logic [SUM_W-1:0]  sum;
  logic              ovf;
  logic              last_r;
  logic [TERM_W-1:0] term_r;

  logic              in_beat;
  logic              take_bin;
  logic              emit;
  logic [SUM_W:0]    sum_ext;
  pdev_req_t         core_req;
  pdev_res_t         core_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_beat   = s_tvalid && s_tready;

  // output register free, or freed by a beat this cycle
  assign emit = (state == S_EMIT) && (!m_tvalid || m_tready);

  // bins are numbered from 1, so a first_bin of zero behaves like one
  assign take_bin = (bin_number >= first_bin) &&
                    (32'(bin_number) <= 32'(MAX_BINS)) &&
                    (s_tdata[31:0] != '0);

  assign core_req.start = in_beat && take_bin;
  assign core_req.pred  = s_tdata[31:0];
  assign core_req.obs   = s_tdata[63:32];

  pdev_core u_core (
    .clk (clk),
    .rst (rst),
    .req (core_req),
    .res (core_res)
  );

  assign sum_ext = {1'b0, sum} + {{(SUM_W + 1 - TERM_W){1'b0}}, term_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_bin <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      first_bin <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bin_number <= 8'd1;
      sum        <= '0;
      ovf        <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            last_r <= s_tlast;
            term_r <= '0;
            if (bin_number != 8'hFF) begin
              bin_number <= bin_number + 8'd1;
            end
            state <= take_bin ? S_RUN : S_ADD;
          end
        end
        S_RUN: begin
          if (core_res.done) begin
            term_r <= core_res.term;
            state  <= S_ADD;
          end
        end
        S_ADD: begin
          if (sum_ext[SUM_W]) begin
            sum <= SUM_MAX;
            ovf <= 1'b1;
          end else begin
            sum <= sum_ext[SUM_W-1:0];
          end
          state <= last_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          // wait only if an earlier result is still unclaimed
          if (emit) begin
            m_tdata    <= sum[SUM_W-1] ? SUM_MAX : {sum[SUM_W-2:0], 1'b0};
            m_tuser[0] <= ovf || sum[SUM_W-1];
            sum        <= '0;
            ovf        <= 1'b0;
            bin_number <= 8'd1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // term core only reports while the sequencer waits for it
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    core_res.done |-> (state == S_RUN))
    else $error("term core finished outside the run state");

  // one bin at a time
  a_one_bin: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_tready)
    else $error("input taken while a bin is in flight");

  // the overflow mark only stands on a clamped sum
  a_ovf_clamped: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (sum == SUM_MAX))
    else $error("overflow mark set on an unclamped sum");

  a_bin_nonzero: assert property (@(posedge clk) disable iff (rst)
    bin_number != '0)
    else $error("bin number reached zero");

endmodule
